>>> hw/rtl/ghcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear hash chunker package
// Shared types, operation codes and defaults for the content-defined chunker.
// ----------------------------------------------------------------------------
package ghcb_pkg;

  localparam int DEFAULT_LANES       = 4;
  localparam int DEFAULT_COUNT_WIDTH = 32;

  localparam int GEAR_WIDTH  = 32;
  localparam int LEN_WIDTH   = 32;
  localparam int BYTE_WIDTH  = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int MASK_WIDTH  = 5;

  localparam logic [MASK_WIDTH-1:0] MASK_BITS_RESET = 5'd13;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_TABLE = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef struct packed {
    logic [1:0]            operation;
    logic [BYTE_WIDTH-1:0] byte_value;
    logic [GEAR_WIDTH-1:0] table_word;
  } in_item_t;

  typedef struct packed {
    logic [LEN_WIDTH-1:0] chunk_length;
    logic                 is_final;
  } out_item_t;

  typedef struct packed {
    logic                  fire;
    logic [1:0]            operation;
    logic [GEAR_WIDTH-1:0] gear;
  } step_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } chunk_result_t;

endpackage

>>> hw/rtl/gear_hash_chunk_boundary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear hash chunk boundary detector
// Content-defined chunker with interleaved gear fingerprints over a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Signals                               Direction
//  item      item_valid, item_ready, item          in  (valid/ready)
//  result    result_valid, result_ready, result    out (valid/ready)
//  config    cfg_wr_en, cfg_wr_data                in  (write only, no wait)
//
// One item is accepted per cycle while the output is not stalled; the accepting
// edge registers the gear table lookup, and the fingerprint update and boundary
// test are registered when that item leaves the first stage.
// A stalled result holds the pipeline; one more item may still enter and wait.
// Reset clears the fingerprints and count and sets the mask to 13; the table
// needs loading.
// ----------------------------------------------------------------------------
module gear_hash_chunk_boundary
  import ghcb_pkg::*;
#(
  parameter int LANES       = DEFAULT_LANES,
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_item_t              item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_item_t             result,
  input  logic                  cfg_wr_en,
  input  logic [MASK_WIDTH-1:0] cfg_wr_data
);

  logic                  s1_valid;
  logic [1:0]            s1_op;
  logic [GEAR_WIDTH-1:0] gear_rd;
  logic [MASK_WIDTH-1:0] mask_bits;
  logic                  advance;
  logic                  accept;
  step_t                 step;
  chunk_result_t         res;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !s1_valid || advance;
  assign accept     = item_valid && item_ready;

  assign step.fire      = s1_valid && advance;
  assign step.operation = s1_op;
  assign step.gear      = gear_rd;

  ghcb_gear_table u_table (
    .clk     (clk),
    .wr_en   (accept && (item.operation == OP_TABLE)),
    .wr_addr (item.byte_value),
    .wr_data (item.table_word),
    .rd_en   (accept),
    .rd_addr (item.byte_value),
    .rd_data (gear_rd)
  );

  ghcb_chunker #(
    .LANES       (LANES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_chunker (
    .clk       (clk),
    .rst       (rst),
    .mask_bits (mask_bits),
    .step      (step),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_bits <= MASK_BITS_RESET;
    end else if (cfg_wr_en) begin
      mask_bits <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op <= item.operation;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.fire && res.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && res.emit) begin
      result <= res.item;
    end
  end

  // A waiting item in the first stage is never dropped while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("first stage item lost during stall");

  // Every reported chunk has at least one byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.chunk_length != '0))
    else $error("zero length chunk reported");

  // With no result pending the block always takes a new item.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with free output");

endmodule

>>> hw/rtl/ghcb_gear_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear table memory
// 256 x 32 table with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ghcb_gear_table
  import ghcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [BYTE_WIDTH-1:0] wr_addr,
  input  logic [GEAR_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [BYTE_WIDTH-1:0] rd_addr,
  output logic [GEAR_WIDTH-1:0] rd_data
);

  logic [GEAR_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/ghcb_chunker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear chunker core
// Holds the lane fingerprints and byte count and decides chunk boundaries.
// ----------------------------------------------------------------------------
module ghcb_chunker
  import ghcb_pkg::*;
#(
  parameter int LANES       = DEFAULT_LANES,
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [MASK_WIDTH-1:0] mask_bits,
  input  step_t                 step,
  output chunk_result_t         res
);

  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

  logic [GEAR_WIDTH-1:0]  lanes [LANES];
  logic [COUNT_WIDTH-1:0] count;
  logic [LANE_W-1:0]      lane_idx;

  logic [GEAR_WIDTH-1:0]        fp_new;
  logic [GEAR_WIDTH-1:0]        mask;
  logic                         hit;
  logic                         count_sat;
  logic [COUNT_WIDTH-1:0]       count_inc;
  logic [LANE_W-1:0]            lane_inc;
  logic [COUNT_WIDTH+31:0]      ext_inc;
  logic [COUNT_WIDTH+31:0]      ext_cur;
  logic [LEN_WIDTH-1:0]         len_inc;
  logic [LEN_WIDTH-1:0]         len_cur;

  always_comb begin
    fp_new    = {lanes[lane_idx][GEAR_WIDTH-2:0], 1'b0} + step.gear;
    mask      = (GEAR_WIDTH'(1) << mask_bits) - GEAR_WIDTH'(1);
    hit       = (fp_new & mask) == mask;
    count_sat = &count;
    count_inc = count_sat ? count : count + COUNT_WIDTH'(1);
    lane_inc  = count_sat ? lane_idx :
                (lane_idx == LANE_LAST) ? '0 : lane_idx + LANE_W'(1);
    ext_inc   = (COUNT_WIDTH + 32)'(count_inc);
    ext_cur   = (COUNT_WIDTH + 32)'(count);
    len_inc   = (|ext_inc[COUNT_WIDTH+31:32]) ? '1 : ext_inc[31:0];
    len_cur   = (|ext_cur[COUNT_WIDTH+31:32]) ? '1 : ext_cur[31:0];
  end

  always_comb begin
    res = '0;
    if (step.fire) begin
      case (step.operation)
        OP_DATA: begin
          res.emit              = hit;
          res.item.chunk_length = len_inc;
          res.item.is_final     = 1'b0;
        end
        OP_END: begin
          res.emit              = |count;
          res.item.chunk_length = len_cur;
          res.item.is_final     = 1'b1;
        end
        default: begin
          res.emit = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        lanes[i] <= '0;
      end
      count    <= '0;
      lane_idx <= '0;
    end else if (step.fire) begin
      case (step.operation)
        OP_DATA: begin
          if (hit) begin
            for (int i = 0; i < LANES; i++) begin
              lanes[i] <= '0;
            end
            count    <= '0;
            lane_idx <= '0;
          end else begin
            lanes[lane_idx] <= fp_new;
            count           <= count_inc;
            lane_idx        <= lane_inc;
          end
        end
        OP_END: begin
          for (int i = 0; i < LANES; i++) begin
            lanes[i] <= '0;
          end
          count    <= '0;
          lane_idx <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> tb/gear_hash_chunk_boundary_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gear hash chunk boundary detector testbench
// Loads the gear table, runs directed byte streams at the reset mask and at
// the mask extremes, then random streams under several mask settings.
// A queue-fed driver and a checking monitor apply random idle gaps on both
// channels. The checker predicts chunk lengths in order and compares each
// result item field by field.
// ----------------------------------------------------------------------------
module gear_hash_chunk_boundary_tb;
  import ghcb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;
  logic cfg_wr_en = 1'b0;
  logic [MASK_WIDTH-1:0] cfg_wr_data = '0;

  logic [GEAR_WIDTH-1:0] gear_mem [0:TABLE_DEPTH-1];
  logic [GEAR_WIDTH-1:0] lane_fp [0:DEFAULT_LANES-1];
  logic [DEFAULT_COUNT_WIDTH-1:0] byte_cnt = '0;
  logic [MASK_WIDTH-1:0] mask_bits_q = MASK_BITS_RESET;
  logic [MASK_WIDTH-1:0] mask_plan [0:8] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd8,
                                             5'd13, 5'd31, 5'd0};

  in_item_t item_q [$];
  out_item_t chunk_q [$];

  int send_gap = 0;
  int recv_wait = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int boundary_seen = 0;
  int final_seen = 0;
  int settings_used = 0;

  gear_hash_chunk_boundary i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_chunk();
    for (int i = 0; i < DEFAULT_LANES; i++) begin
      lane_fp[i] = '0;
    end
    byte_cnt = '0;
  endfunction

  function automatic void chunk_predict(input in_item_t it);
    int lane;
    logic [GEAR_WIDTH-1:0] fp;
    logic [GEAR_WIDTH-1:0] mask;
    logic [DEFAULT_COUNT_WIDTH-1:0] next_cnt;
    out_item_t exp_item;
    case (it.operation)
      OP_TABLE: begin
        gear_mem[it.byte_value] = it.table_word;
      end
      OP_END: begin
        if (byte_cnt != 0) begin
          exp_item.chunk_length = byte_cnt;
          exp_item.is_final = 1'b1;
          chunk_q.push_back(exp_item);
        end
        clear_chunk();
      end
      OP_DATA: begin
        lane = byte_cnt % DEFAULT_LANES;
        mask = (32'd1 << mask_bits_q) - 32'd1;
        fp = (lane_fp[lane] << 1) + gear_mem[it.byte_value];
        next_cnt = (byte_cnt == '1) ? byte_cnt : byte_cnt + 1'b1;
        lane_fp[lane] = fp;
        if ((fp & mask) == mask) begin
          exp_item.chunk_length = next_cnt;
          exp_item.is_final = 1'b0;
          chunk_q.push_back(exp_item);
          clear_chunk();
        end else begin
          byte_cnt = next_cnt;
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else if (!item_valid || item_ready) begin
      if (item_valid) begin
        chunk_predict(item);
        items_sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (item_q.size() != 0) begin
        item <= item_q.pop_front();
        item_valid <= 1'b1;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        send_gap = tx_burst ? 0 : $urandom_range(0, 16);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      result_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (result.is_final) final_seen++;
        else boundary_seen++;
        if (chunk_q.size() == 0) begin
          $error("Unexpected result item: chunk_length %0d, is_final %0d",
                 result.chunk_length, result.is_final);
          fail_count++;
        end else begin
          exp_item = chunk_q.pop_front();
          if (result.chunk_length !== exp_item.chunk_length) begin
            $error("chunk_length mismatch: expected %0d, actual %0d",
                   exp_item.chunk_length, result.chunk_length);
            fail_count++;
          end
          if (result.is_final !== exp_item.is_final) begin
            $error("is_final mismatch: expected %0d, actual %0d",
                   exp_item.is_final, result.is_final);
            fail_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        recv_wait = rx_burst ? 0 : $urandom_range(0, 16);
        if (results_seen == 30 || $urandom_range(0, 299) == 0) recv_wait = 250;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [7:0] byte_val,
                           input logic [31:0] word);
    in_item_t it;
    it.operation = op;
    it.byte_value = byte_val;
    it.table_word = word;
    item_q.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (item_q.size() != 0 || item_valid || chunk_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_WIDTH-1:0] m);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mask_bits_q = m;
    settings_used++;
  endtask

  // Mostly well-formed streams ended by an end of stream, with table
  // rewrites, stray ends, unfinished streams and unused opcodes mixed in.
  task automatic push_random_phase(input int budget);
    int n;
    int len;
    int roll;
    n = 0;
    while (n < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_item(OP_TABLE, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
        n++;
      end else if (roll < 7) begin
        push_item(OP_UNUSED, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
      end else if (roll < 10) begin
        push_item(OP_END, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
        n++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
          push_item(OP_DATA, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
        end
        n += len;
        if ($urandom_range(0, 9) != 0) begin
          push_item(OP_END, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_DEPTH; i++) begin
      push_item(OP_TABLE, BYTE_WIDTH'(i), $urandom);
    end
    push_item(OP_TABLE, 8'h00, 32'h0000_0000);
    push_item(OP_TABLE, 8'hFF, 32'hFFFF_FFFF);
    push_item(OP_TABLE, 8'h7F, 32'h7FFF_FFFF);

    // At the reset mask: empty end, unused opcode, single-byte boundaries,
    // a final remainder, and a table rewrite used right after.
    push_item(OP_END, 8'h00, 32'h0);
    push_item(OP_UNUSED, 8'hA5, 32'hFFFF_FFFF);
    push_item(OP_DATA, 8'h7F, 32'h0);
    push_item(OP_DATA, 8'h00, 32'h0);
    push_item(OP_DATA, 8'h00, 32'h0);
    push_item(OP_DATA, 8'h00, 32'h0);
    push_item(OP_END, 8'hFF, 32'h0);
    push_item(OP_DATA, 8'hFF, 32'hFFFF_FFFF);
    push_item(OP_TABLE, 8'h10, 32'h0000_1FFF);
    push_item(OP_DATA, 8'h00, 32'h0);
    push_item(OP_DATA, 8'h10, 32'h0);
    push_item(OP_END, 8'h00, 32'h0);

    write_mask(5'd31);
    push_item(OP_DATA, 8'h7F, 32'h0);
    push_item(OP_DATA, 8'hFF, 32'h0);
    push_item(OP_DATA, 8'h00, 32'h0);
    push_item(OP_END, 8'h00, 32'h0);

    write_mask(5'd0);
    for (int k = 0; k < 4; k++) begin
      push_item(OP_DATA, BYTE_WIDTH'($urandom_range(0, 255)), $urandom);
    end
    push_item(OP_END, 8'h00, 32'h0);

    for (int p = 0; p < 10; p++) begin
      write_mask((p < 9) ? mask_plan[p] : MASK_WIDTH'($urandom_range(1, 31)));
      push_random_phase(50);
    end

    wait_idle();
    $display("Run covered %0d items under %0d mask settings after reset.",
             items_sent, settings_used);
    $display("Checked %0d boundary chunks and %0d end-of-stream chunks.",
             boundary_seen, final_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the chunker to drain.");
    $display("Regression FAIL");
    $finish;
  end

endmodule
